/* sv/gfc_pkg.sv */
// Package for the grayscale GIF frame compositor.
// Holds sizes, operation and command codes, shared types and helpers.
// No dependencies.
`default_nettype none
package gfc_pkg;

   localparam int unsigned MAX_CANVAS_WIDTH  = 256;
   localparam int unsigned MAX_CANVAS_HEIGHT = 256;
   localparam int unsigned PALETTE_ENTRIES   = 256;
   localparam int unsigned CANVAS_CELLS      = MAX_CANVAS_WIDTH * MAX_CANVAS_HEIGHT;
   localparam int unsigned CANVAS_AW         = $clog2(CANVAS_CELLS);
   localparam int unsigned PAL_AW            = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int unsigned Q_DEPTH           = 8;
   localparam int unsigned Q_AW              = $clog2(Q_DEPTH);

   // Luma weights in 16-bit fixed point.
   localparam logic [15:0] LUMA_R = 16'd19595;
   localparam logic [15:0] LUMA_G = 16'd38470;
   localparam logic [15:0] LUMA_B = 16'd7471;

   localparam logic [2:0] DISPOSE_CLEAR   = 3'd2;
   localparam logic [2:0] DISPOSE_RESTORE = 3'd3;

   localparam logic [1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_CANVAS_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_DISPOSE_OVR   = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BEYOND  = 2'd1;
   localparam logic [1:0] ST_OUTSIDE = 2'd2;

   typedef enum logic [2:0] {
      OP_PALETTE = 3'd0,
      OP_START   = 3'd1,
      OP_PIXEL   = 3'd2,
      OP_READ    = 3'd3,
      OP_END     = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CMD_NOP     = 3'd0,
      CMD_WRITE   = 3'd1,
      CMD_READ    = 3'd2,
      CMD_SAVE    = 3'd3,
      CMD_CLEAR   = 3'd4,
      CMD_RESTORE = 3'd5
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [CANVAS_AW-1:0] addr;
      logic [7:0]           gray;
      logic [1:0]           status;
   } cmd_type;

   typedef struct packed {
      logic init_done;
   } back_status_type;

   typedef enum logic [2:0] {
      B_CLEAR   = 3'd0,
      B_SAVE    = 3'd1,
      B_RESTORE = 3'd2,
      B_READ    = 3'd3,
      B_IDLE    = 3'd4
   } back_state_type;

   // Zero acts as one, values above the maximum saturate.
   function automatic logic [16:0] clamp_dim(input logic [8:0] v, input int unsigned maxv);
      logic [16:0] r;
      if (v == 9'd0) begin
         r = 17'd1;
      end else if (32'(v) > maxv) begin
         r = 17'(maxv);
      end else begin
         r = 17'(v);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* sv/gfc_if.sv */
// Channel interfaces of the compositor: request and response.
// Depends on nothing.
`default_nettype none
interface gfc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [7:0]  index;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic        local_palette;
   logic [15:0] x_pos;
   logic [15:0] y_pos;
   logic [15:0] span_width;
   logic [15:0] span_height;
   logic        transparent_on;
   logic [2:0]  disposal;
   modport source(output valid, operation, index, red, green, blue, local_palette, x_pos,
                  y_pos, span_width, span_height, transparent_on, disposal, input ready);
   modport sink(input valid, operation, index, red, green, blue, local_palette, x_pos,
                y_pos, span_width, span_height, transparent_on, disposal, output ready);
endinterface

interface gfc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_value;
   logic [1:0] status;
   modport source(output valid, read_value, status, input ready);
   modport sink(input valid, read_value, status, output ready);
endinterface
`default_nettype wire

/* sv/gfc_front.sv */
// Front end: takes requests, keeps frame state and palettes, emits canvas commands.
// Depends on gfc_pkg and gfc_req_if.
`default_nettype none
module gfc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   gfc_req_if.sink                   req,
   input  wire logic                 csr_write_enable,
   input  wire logic [1:0]           csr_index,
   input  wire logic [8:0]           csr_write_data,
   input  wire logic [gfc_pkg::Q_AW:0] q_count,
   input  gfc_pkg::back_status_type  back_status,
   output logic                      q_push,
   output gfc_pkg::cmd_type          q_push_cmd
);
   import gfc_pkg::*;

   logic [8:0]  cw_reg_ff, ch_reg_ff;
   logic        ovr_ff;
   logic [15:0] left_ff, top_ff, cols_ff, rows_ff;
   logic        trans_en_ff, use_local_ff;
   logic [7:0]  trans_idx_ff;
   logic [2:0]  disp_ff;
   logic [15:0] col_ff, col_in;
   logic [16:0] row_ff, row_in;

   logic        s1_v_ff, s2_v_ff, s3_v_ff;
   cmd_type     s1_cmd_ff, s2_cmd_ff, s3_cmd_ff, s0_cmd;
   logic        s1_we_ff, s2_we_ff, s0_we;
   logic        s1_loc_ff, s2_loc_ff, s3_loc_ff, s0_loc;
   logic [7:0]  s1_idx_ff, s2_idx_ff;
   logic        s2_ok_ff, s3_ok_ff;
   logic [7:0]  s1_r_ff, s1_g_ff, s1_b_ff;
   logic [23:0] s2_pr_ff, s2_pg_ff, s2_pb_ff;
   logic [24:0] luma_sum;
   logic [7:0]  glob_rd_ff, loc_rd_ff, sel_gray;
   logic [7:0]  glob_mem [PALETTE_ENTRIES];
   logic [7:0]  loc_mem [PALETTE_ENTRIES];

   logic        accept;
   logic [Q_AW+2:0] occupancy;
   logic [16:0] cw, ch, x_sum;
   logic [17:0] y_sum;
   logic [CANVAS_AW-1:0] pix_addr, rd_addr;
   op_type      op;

   assign occupancy = (Q_AW+3)'(q_count) + (Q_AW+3)'(s1_v_ff) + (Q_AW+3)'(s2_v_ff)
                      + (Q_AW+3)'(s3_v_ff);
   assign req.ready = back_status.init_done && (occupancy < (Q_AW+3)'(Q_DEPTH));
   assign accept    = req.valid && req.ready;
   assign op        = op_type'(req.operation);

   assign cw    = clamp_dim(cw_reg_ff, MAX_CANVAS_WIDTH);
   assign ch    = clamp_dim(ch_reg_ff, MAX_CANVAS_HEIGHT);
   assign x_sum = {1'b0, left_ff} + {1'b0, col_ff};
   assign y_sum = {2'b00, top_ff} + {1'b0, row_ff};
   assign pix_addr = CANVAS_AW'(32'(y_sum) * 32'(MAX_CANVAS_WIDTH) + 32'(x_sum));
   assign rd_addr  = CANVAS_AW'(32'(req.y_pos) * 32'(MAX_CANVAS_WIDTH) + 32'(req.x_pos));

   // Classification of the accepted item and the pixel counter update.
   always_comb begin
      s0_cmd        = '{kind: CMD_NOP, addr: '0, gray: 8'd0, status: ST_OK};
      s0_we         = 1'b0;
      s0_loc        = use_local_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      case (op)
         OP_PALETTE: begin
            s0_we  = ({1'b0, req.index} < 9'(PALETTE_ENTRIES));
            s0_loc = req.local_palette;
         end
         OP_START: begin
            s0_cmd.kind = CMD_SAVE;
            col_in      = 16'd0;
            row_in      = 17'd0;
         end
         OP_PIXEL: begin
            if (cols_ff == 16'd0 || row_ff >= {1'b0, rows_ff}) begin
               s0_cmd.status = ST_BEYOND;
            end else begin
               if ({1'b0, col_ff} + 17'd1 >= {1'b0, cols_ff}) begin
                  col_in = 16'd0;
                  row_in = row_ff + 17'd1;
               end else begin
                  col_in = col_ff + 16'd1;
               end
               if (trans_en_ff && req.index == trans_idx_ff) begin
                  s0_cmd.status = ST_OK;
               end else if (x_sum >= cw || y_sum >= {1'b0, ch}) begin
                  s0_cmd.status = ST_OUTSIDE;
               end else begin
                  s0_cmd.kind = CMD_WRITE;
                  s0_cmd.addr = pix_addr;
               end
            end
         end
         OP_READ: begin
            if ({1'b0, req.x_pos} >= cw || {1'b0, req.y_pos} >= ch) begin
               s0_cmd.status = ST_OUTSIDE;
            end else begin
               s0_cmd.kind = CMD_READ;
               s0_cmd.addr = rd_addr;
            end
         end
         OP_END: begin
            if (disp_ff == DISPOSE_CLEAR || ovr_ff) begin
               s0_cmd.kind = CMD_CLEAR;
            end else if (disp_ff == DISPOSE_RESTORE) begin
               s0_cmd.kind = CMD_RESTORE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_reg_ff <= 9'd256;
         ch_reg_ff <= 9'd256;
         ovr_ff    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:  cw_reg_ff <= csr_write_data;
            CSR_CANVAS_HEIGHT: ch_reg_ff <= csr_write_data;
            CSR_DISPOSE_OVR:   ovr_ff    <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0; top_ff <= '0; cols_ff <= '0; rows_ff <= '0;
         trans_en_ff <= 1'b0; trans_idx_ff <= '0; disp_ff <= '0; use_local_ff <= 1'b0;
         col_ff <= '0; row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (op == OP_START) begin
            left_ff      <= req.x_pos;
            top_ff       <= req.y_pos;
            cols_ff      <= req.span_width;
            rows_ff      <= req.span_height;
            trans_en_ff  <= req.transparent_on;
            trans_idx_ff <= req.index;
            disp_ff      <= req.disposal;
            use_local_ff <= req.local_palette;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff <= s0_cmd;
      s1_we_ff  <= s0_we;
      s1_loc_ff <= s0_loc;
      s1_idx_ff <= req.index;
      s1_r_ff   <= req.red;
      s1_g_ff   <= req.green;
      s1_b_ff   <= req.blue;
      s2_cmd_ff <= s1_cmd_ff;
      s2_we_ff  <= s1_we_ff;
      s2_loc_ff <= s1_loc_ff;
      s2_idx_ff <= s1_idx_ff;
      s2_ok_ff  <= ({1'b0, s1_idx_ff} < 9'(PALETTE_ENTRIES));
      s2_pr_ff  <= LUMA_R * {8'd0, s1_r_ff};
      s2_pg_ff  <= LUMA_G * {8'd0, s1_g_ff};
      s2_pb_ff  <= LUMA_B * {8'd0, s1_b_ff};
      s3_cmd_ff <= s2_cmd_ff;
      s3_loc_ff <= s2_loc_ff;
      s3_ok_ff  <= s2_ok_ff;
   end

   assign luma_sum = {1'b0, s2_pr_ff} + {1'b0, s2_pg_ff} + {1'b0, s2_pb_ff};

   // Palette tables: written by palette items, read for every item at its index.
   always_ff @(posedge clock) begin
      if (s2_v_ff && s2_we_ff) begin
         if (s2_loc_ff) begin
            loc_mem[s2_idx_ff[PAL_AW-1:0]] <= luma_sum[23:16];
         end else begin
            glob_mem[s2_idx_ff[PAL_AW-1:0]] <= luma_sum[23:16];
         end
      end
      glob_rd_ff <= glob_mem[s2_idx_ff[PAL_AW-1:0]];
      loc_rd_ff  <= loc_mem[s2_idx_ff[PAL_AW-1:0]];
   end

   assign sel_gray = s3_ok_ff ? (s3_loc_ff ? loc_rd_ff : glob_rd_ff) : 8'd0;

   always_comb begin
      q_push_cmd      = s3_cmd_ff;
      q_push_cmd.gray = sel_gray;
   end
   assign q_push = s3_v_ff;

endmodule
`default_nettype wire

/* sv/gfc_queue.sv */
// Short command queue between the front end and the canvas back end.
// Depends on gfc_pkg.
`default_nettype none
module gfc_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  gfc_pkg::cmd_type            push_cmd,
   input  wire logic                   pop,
   output logic                        head_valid,
   output gfc_pkg::cmd_type            head_cmd,
   output logic [gfc_pkg::Q_AW:0]      count
);
   import gfc_pkg::*;

   cmd_type         slot_ff [Q_DEPTH];
   logic [Q_AW-1:0] wr_ff, rd_ff;
   logic [Q_AW:0]   count_ff;

   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ff];
   assign count      = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         count_ff <= count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

/* sv/gfc_back.sv */
// Back end: owns the canvas and its saved copy, runs pixel writes, reads and sweeps.
// Depends on gfc_pkg and gfc_rsp_if.
`default_nettype none
module gfc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_valid,
   input  gfc_pkg::cmd_type         q_cmd,
   output logic                     q_pop,
   gfc_rsp_if.source                rsp,
   output gfc_pkg::back_status_type back_status
);
   import gfc_pkg::*;

   back_state_type state_ff, state_in;
   logic [CANVAS_AW:0]   cnt_ff;
   logic                 pend_ff;
   logic [CANVAS_AW-1:0] pend_addr_ff;
   logic                 init_done_ff;
   logic                 rsp_v_ff;
   logic [7:0]           rsp_val_ff;
   logic [1:0]           rsp_st_ff;

   logic [7:0] canvas_mem [CANVAS_CELLS];
   logic [7:0] saved_mem [CANVAS_CELLS];
   logic [7:0] canvas_rd_ff, saved_rd_ff;

   logic                 out_free, sweeping, issuing, sweep_done;
   logic                 canvas_we, saved_we;
   logic [CANVAS_AW-1:0] canvas_wa, canvas_ra, saved_wa, saved_ra;
   logic [7:0]           canvas_wd;

   assign out_free   = !rsp_v_ff || rsp.ready;
   assign q_pop      = (state_ff == B_IDLE) && q_valid && out_free;
   assign issuing    = (cnt_ff < (CANVAS_AW+1)'(CANVAS_CELLS));
   assign sweep_done = !issuing;
   assign sweeping   = (state_ff == B_CLEAR) || (state_ff == B_SAVE) || (state_ff == B_RESTORE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               case (q_cmd.kind)
                  CMD_READ:    state_in = B_READ;
                  CMD_SAVE:    state_in = B_SAVE;
                  CMD_CLEAR:   state_in = B_CLEAR;
                  CMD_RESTORE: state_in = B_RESTORE;
                  default:     state_in = B_IDLE;
               endcase
            end
         end
         B_READ: state_in = B_IDLE;
         B_CLEAR, B_SAVE, B_RESTORE: begin
            if (sweep_done) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // Memory port control for each state.
   always_comb begin
      canvas_we = 1'b0;
      canvas_wa = q_cmd.addr;
      canvas_wd = q_cmd.gray;
      canvas_ra = q_cmd.addr;
      saved_we  = pend_ff;
      saved_wa  = pend_addr_ff;
      saved_ra  = cnt_ff[CANVAS_AW-1:0];
      unique case (state_ff)
         B_IDLE: begin
            canvas_we = q_pop && (q_cmd.kind == CMD_WRITE);
            saved_we  = 1'b0;
         end
         B_CLEAR: begin
            canvas_we = issuing;
            canvas_wa = cnt_ff[CANVAS_AW-1:0];
            canvas_wd = 8'd0;
            saved_we  = 1'b0;
         end
         B_SAVE: begin
            canvas_ra = cnt_ff[CANVAS_AW-1:0];
         end
         B_RESTORE: begin
            canvas_we = pend_ff;
            canvas_wa = pend_addr_ff;
            canvas_wd = saved_rd_ff;
            saved_we  = 1'b0;
         end
         default: begin
            saved_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (canvas_we) begin
         canvas_mem[canvas_wa] <= canvas_wd;
      end
      canvas_rd_ff <= canvas_mem[canvas_ra];
   end

   always_ff @(posedge clock) begin
      if (saved_we) begin
         saved_mem[saved_wa] <= canvas_rd_ff;
      end
      saved_rd_ff <= saved_mem[saved_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         init_done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= ((state_ff == B_SAVE) || (state_ff == B_RESTORE)) && issuing;
         if (sweeping && issuing) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (!sweeping) begin
            cnt_ff <= '0;
         end
         if (state_ff == B_CLEAR && sweep_done) begin
            init_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= cnt_ff[CANVAS_AW-1:0];
   end

   // A canvas read answers from the B_READ state that follows the pop, once the memory data is registered.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (q_pop && q_cmd.kind != CMD_READ) begin
         rsp_v_ff <= 1'b1;
      end else if (state_ff == B_READ) begin
         rsp_v_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_cmd.kind != CMD_READ) begin
         rsp_val_ff <= 8'd0;
         rsp_st_ff  <= q_cmd.status;
      end else if (state_ff == B_READ) begin
         rsp_val_ff <= canvas_rd_ff;
         rsp_st_ff  <= ST_OK;
      end
   end

   assign rsp.valid             = rsp_v_ff;
   assign rsp.read_value        = rsp_val_ff;
   assign rsp.status            = rsp_st_ff;
   assign back_status.init_done = init_done_ff;

endmodule
`default_nettype wire

/* sv/gif_frame_gray_compositor_core.sv */
// Pixel writes and out-of-area items: one per cycle while the queue has room and responses are
// taken; the response is offered after the front-end pipeline, the command queue and the
// response register. Canvas reads: no further command is popped while a read is in B_READ.
// Frame start and clearing or restoring frame ends sweep the whole canvas memory through
// its one read and one write port. Reset is synchronous; afterwards a clearing pass zeroes
// the canvas, during which no request is taken (configuration writes are).
`default_nettype none
module gif_frame_gray_compositor_core (
   input  wire logic       clock,
   input  wire logic       reset,
   gfc_req_if.sink         req_ch,
   gfc_rsp_if.source       rsp_ch,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [8:0] csr_write_data
);
   import gfc_pkg::*;

   logic            q_push, q_pop, q_head_valid;
   cmd_type         q_push_cmd, q_head_cmd;
   logic [Q_AW:0]   q_count;
   back_status_type back_status;

   gfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .q_count          (q_count),
      .back_status      (back_status),
      .q_push           (q_push),
      .q_push_cmd       (q_push_cmd)
   );

   gfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_cmd   (q_head_cmd),
      .count      (q_count)
   );

   gfc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_head_valid),
      .q_cmd       (q_head_cmd),
      .q_pop       (q_pop),
      .rsp         (rsp_ch),
      .back_status (back_status)
   );

endmodule
`default_nettype wire

/* sv/gfc_checker.sv */
// Port-level checks for the compositor top level, with the bind that attaches them.
// Depends on gfc_pkg, gif_frame_gray_compositor_core and the channel interfaces.
`default_nettype none
module gfc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_value,
   input wire logic [1:0] rsp_status
);
   import gfc_pkg::*;

   // A waiting response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_read_value) && $stable(rsp_status))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   // Only a successful read carries a gray value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_read_value == 8'd0)
      else $error("value on a failed response");

   // The clearing pass after reset holds off requests.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !req_ready)
      else $error("request taken during the clearing pass");

endmodule

bind gif_frame_gray_compositor_core gfc_checker u_gfc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_status     (rsp_ch.status)
);
`default_nettype wire
